/* hdl/bfc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared constants and types of the bitmap font text console.
// ----------------------------------------------------------------------------
package bfc_pkg;

  localparam int GLYPH_WIDTH    = 8;
  localparam int MAX_GLYPH_ROWS = 32;
  localparam int GLYPH_SLOTS    = 256;
  localparam int STORE_DEPTH    = GLYPH_SLOTS * MAX_GLYPH_ROWS;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int ROW_AW         = $clog2(MAX_GLYPH_ROWS);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // input functions
  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_LOAD = 2'd2;

  // result kinds
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // configuration register indexes
  localparam logic [7:0] CFG_TEXT_COLS   = 8'd0;
  localparam logic [7:0] CFG_TEXT_ROWS   = 8'd1;
  localparam logic [7:0] CFG_GLYPH_ROWS  = 8'd2;
  localparam logic [7:0] CFG_GLYPH_COUNT = 8'd3;

  localparam logic [9:0] TEXT_COLS_RST   = 10'd80;
  localparam logic [9:0] TEXT_ROWS_RST   = 10'd25;
  localparam logic [5:0] GLYPH_ROWS_RST  = 6'd16;
  localparam logic [8:0] GLYPH_COUNT_RST = 9'd256;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ROWS,
    SEQ_SCROLL
  } seq_state_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [7:0]  row_bits;
    logic [31:0] draw_fg;
    logic [31:0] draw_bg;
    logic [5:0]  scroll_lines;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

/* hdl/bfc_chan_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfc channel interfaces
// Valid/ready channels of the console: character input, results, config.
// ----------------------------------------------------------------------------
interface bfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  char_code;
  logic [9:0]  set_col;
  logic [9:0]  set_row;
  logic [12:0] glyph_addr;
  logic [7:0]  glyph_byte;
  logic [31:0] fg_color;
  logic [31:0] bg_color;

  modport source (output valid, func, char_code, set_col, set_row, glyph_addr,
                  glyph_byte, fg_color, bg_color, input ready);
  modport sink (input valid, func, char_code, set_col, set_row, glyph_addr,
                glyph_byte, fg_color, bg_color, output ready);
endinterface

interface bfc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [7:0]  row_bits;
  logic [31:0] draw_fg;
  logic [31:0] draw_bg;
  logic [5:0]  scroll_lines;
  logic        last;

  modport source (output valid, kind, pixel_x, pixel_y, row_bits, draw_fg,
                  draw_bg, scroll_lines, last, input ready);
  modport sink (input valid, kind, pixel_x, pixel_y, row_bits, draw_fg,
                draw_bg, scroll_lines, last, output ready);
endinterface

interface bfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* hdl/bfc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/bitmap_font_text_console_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_font_text_console_unit
// Text console engine: cursor, loadable 8-pixel-wide glyph store, draw/scroll.
// ----------------------------------------------------------------------------
// A put-character item is accepted at the input, then the sequencer issues
// one glyph-store read per drawn pixel row (glyph_rows, capped at 32) through
// the single port of the glyph memory, and a scroll result if it scrolls.
// Results stream out one per cycle while the output is not stalled, held in
// stage 1 during the read and given their row bits in the output register.
// Newline, set-cursor and glyph-load items end at acceptance; a scrolling
// newline adds a scroll result. The glyph store has no clearing pass: entries
// read before they are loaded return undefined row bits. Configuration writes
// are taken in any cycle and must be made while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_font_text_console_unit (
  input  logic      clk,
  input  logic      rst_n,
  bfc_in_if.sink    in_chan,
  bfc_out_if.source out_chan,
  bfc_cfg_if.sink   cfg_chan
);
  import bfc_pkg::*;

  // configuration
  logic [9:0] text_cols_r;
  logic [9:0] text_rows_r;
  logic [5:0] glyph_rows_r;
  logic [8:0] glyph_count_r;

  // cursor
  logic [9:0] cur_col_r, cur_col_nxt;
  logic [9:0] cur_row_r, cur_row_nxt;

  // per-item context
  logic [31:0]       fg_r, bg_r;
  logic [7:0]        glyph_r;
  logic [15:0]       px_r;
  logic [15:0]       ybase_r;
  logic [5:0]        rows_r;
  logic              scroll_r;
  logic [ROW_AW-1:0] row_cnt_r;

  seq_state_t state_r, state_nxt;

  // pipeline: stage 1 waits on the glyph read, stage 2 is the output register
  logic    s1_valid_r, s2_valid_r;
  result_t s1_r, s2_r, s1_nxt;
  logic    adv1, adv2;

  logic in_acc;
  logic issue_row, issue_scroll, last_row;

  logic [STORE_AW-1:0] ram_addr;
  logic                ram_we, ram_re;
  logic [7:0]          ram_q;

  // put-character arithmetic
  logic [5:0]  rows_eff;
  logic [7:0]  glyph_sel;
  logic [10:0] col_inc;
  logic        col_wrap;
  logic [10:0] row_up;
  logic        scroll_nxt;
  logic [10:0] row_fin;
  logic [15:0] ybase_nxt;
  logic        is_newline;

  assign in_acc     = in_chan.valid && in_chan.ready;
  assign is_newline = (in_chan.char_code == NEWLINE_CODE);

  assign rows_eff  = (glyph_rows_r > 6'(MAX_GLYPH_ROWS)) ? 6'(MAX_GLYPH_ROWS)
                                                         : glyph_rows_r;
  assign glyph_sel = ({1'b0, in_chan.char_code} >= glyph_count_r) ? 8'd0
                                                                  : in_chan.char_code;
  assign col_inc   = {1'b0, cur_col_r} + 11'd1;
  assign col_wrap  = (col_inc >= {1'b0, text_cols_r});
  assign ybase_nxt = {6'd0, cur_row_r} * {10'd0, rows_eff};

  always_comb begin
    if (is_newline) begin
      row_up = {1'b0, cur_row_r} + 11'd1;
    end else begin
      row_up = {1'b0, cur_row_r} + {10'd0, col_wrap};
    end
    scroll_nxt = (row_up >= {1'b0, text_rows_r});
    row_fin    = scroll_nxt ? (row_up - 11'd1) : row_up;
  end

  // cursor update at acceptance
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (in_acc) begin
      unique case (in_chan.func)
        FUNC_PUT: begin
          if (is_newline || col_wrap) begin
            cur_col_nxt = 10'd0;
          end else begin
            cur_col_nxt = col_inc[9:0];
          end
          cur_row_nxt = row_fin[9:0];
        end
        FUNC_SET: begin
          cur_col_nxt = in_chan.set_col;
          cur_row_nxt = in_chan.set_row;
        end
        default: begin
        end
      endcase
    end
  end

  assign adv2     = !s2_valid_r || out_chan.ready;
  assign adv1     = !s1_valid_r || adv2;
  assign last_row = ({1'b0, row_cnt_r} == (rows_r - 6'd1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_acc && in_chan.func == FUNC_PUT) begin
          if (!is_newline && rows_eff != 6'd0) begin
            state_nxt = SEQ_ROWS;
          end else if (scroll_nxt) begin
            state_nxt = SEQ_SCROLL;
          end
        end
      end
      SEQ_ROWS: begin
        if (adv1 && last_row) begin
          state_nxt = scroll_r ? SEQ_SCROLL : SEQ_IDLE;
        end
      end
      SEQ_SCROLL: begin
        if (adv1) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_chan.ready = (state_r == SEQ_IDLE);
    issue_row     = (state_r == SEQ_ROWS) && adv1;
    issue_scroll  = (state_r == SEQ_SCROLL) && adv1;
    ram_re        = issue_row;
    ram_we        = in_acc && (in_chan.func == FUNC_LOAD);
    if (state_r == SEQ_ROWS) begin
      ram_addr = {glyph_r, row_cnt_r};
    end else begin
      ram_addr = in_chan.glyph_addr;
    end
  end

  // stage 1 contents of the next issued result
  always_comb begin
    s1_nxt          = '0;
    s1_nxt.draw_fg  = fg_r;
    s1_nxt.draw_bg  = bg_r;
    if (issue_scroll) begin
      s1_nxt.kind         = KIND_SCROLL;
      s1_nxt.scroll_lines = rows_r;
      s1_nxt.last         = 1'b1;
    end else begin
      s1_nxt.kind    = KIND_DRAW;
      s1_nxt.pixel_x = px_r;
      s1_nxt.pixel_y = ybase_r + 16'(row_cnt_r);
      s1_nxt.last    = last_row && !scroll_r;
    end
  end

  bfc_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (in_chan.glyph_byte),
    .rdata (ram_q)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= SEQ_IDLE;
      cur_col_r     <= 10'd0;
      cur_row_r     <= 10'd0;
      text_cols_r   <= TEXT_COLS_RST;
      text_rows_r   <= TEXT_ROWS_RST;
      glyph_rows_r  <= GLYPH_ROWS_RST;
      glyph_count_r <= GLYPH_COUNT_RST;
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cfg_chan.valid) begin
        unique case (cfg_chan.addr)
          CFG_TEXT_COLS:   text_cols_r   <= cfg_chan.data[9:0];
          CFG_TEXT_ROWS:   text_rows_r   <= cfg_chan.data[9:0];
          CFG_GLYPH_ROWS:  glyph_rows_r  <= cfg_chan.data[5:0];
          CFG_GLYPH_COUNT: glyph_count_r <= cfg_chan.data[8:0];
          default: begin
          end
        endcase
      end
      if (issue_row || issue_scroll) begin
        s1_valid_r <= 1'b1;
      end else if (adv2) begin
        s1_valid_r <= 1'b0;
      end
      if (adv2) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  assign cfg_chan.ready = 1'b1;

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && in_chan.func == FUNC_PUT) begin
      fg_r     <= in_chan.fg_color;
      bg_r     <= in_chan.bg_color;
      glyph_r  <= glyph_sel;
      px_r     <= {3'd0, cur_col_r, 3'd0};
      ybase_r  <= ybase_nxt;
      rows_r   <= rows_eff;
      scroll_r <= scroll_nxt;
    end
    if (in_acc) begin
      row_cnt_r <= '0;
    end else if (issue_row) begin
      row_cnt_r <= row_cnt_r + 1'b1;
    end
    if (issue_row || issue_scroll) begin
      s1_r <= s1_nxt;
    end
    // merge glyph bits as the result moves into the output register
    if (adv2) begin
      s2_r <= s1_r;
      if (s1_r.kind == KIND_DRAW) begin
        s2_r.row_bits <= ram_q;
      end else begin
        s2_r.row_bits <= 8'd0;
      end
    end
  end

  assign out_chan.valid        = s2_valid_r;
  assign out_chan.kind         = s2_r.kind;
  assign out_chan.pixel_x      = s2_r.pixel_x;
  assign out_chan.pixel_y      = s2_r.pixel_y;
  assign out_chan.row_bits     = s2_r.row_bits;
  assign out_chan.draw_fg      = s2_r.draw_fg;
  assign out_chan.draw_bg      = s2_r.draw_bg;
  assign out_chan.scroll_lines = s2_r.scroll_lines;
  assign out_chan.last         = s2_r.last;

endmodule
`default_nettype wire
